[src/sdq_pkg.sv]
// Shared types and constants of the sequence dispatch queue.
// Used by every module of the block but sdq_ram; depends on nothing.
package sdq_pkg;

	localparam int QUEUE_CAPACITY  = 512;
	localparam int HANDLE_BITS     = 16;
	localparam int PTR_W           = $clog2(QUEUE_CAPACITY);
	localparam int CNT_W           = $clog2(QUEUE_CAPACITY + 1);
	localparam int DEPTH_W         = 10;
	localparam int ID_W            = 16;
	localparam int TOTAL_W         = 32;
	localparam int REQ_W           = 3;
	localparam int IN_TDATA_W      = 24;
	localparam int OUT_TDATA_W     = 112;
	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET = DEPTH_W'(500);

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQUEUE  = 3'd0,
		REQ_COMPLETE = 3'd1,
		REQ_CLEAR    = 3'd2,
		REQ_STATUS   = 3'd3,
		REQ_PAUSE    = 3'd4,
		REQ_RESUME   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_PAUSED  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_CAP,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic  load;
		logic  enq;
		logic  reject;
		logic  complete;
		logic  clear;
		logic  mode_we;
		mode_t mode_val;
		logic  set_empty;
		logic  pop;
	} sdq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t  req;
		mode_t mode;
		logic  busy;
		logic  count_zero;
		logic  full;
	} sdq_status_t;

endpackage

[src/sequence_dispatch_queue_unit.sv]
// Top level of the sequence dispatch queue: controller plus datapath.
// Depends on sdq_pkg, sdq_ctrl, sdq_datapath (and sdq_ram below it).
//
//  channel  direction  signals                      accepted when
//  s_*      in         tvalid/tready/tuser/tdata    s_tvalid & s_tready
//  m_*      out        tvalid/tready/tdata          m_tvalid & m_tready
//  cfg_*    in         valid/ready/data (max_depth) cfg_valid & cfg_ready
//
// One item at a time: after acceptance the request executes; a dispatch then reads the
// handle RAM (ST_READ, then ST_CAP while its registered read port returns the handle)
// before the result is shown, and the block goes idle once the result is taken.
// A stalled result holds the block; the next item is taken after it leaves.
// Reset is asynchronous; no clearing pass, the handle RAM is read only where written.
// Configuration writes are taken in any cycle.
module sequence_dispatch_queue_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sdq_pkg::REQ_W-1:0]        s_tuser,  // req_type
	input  logic [sdq_pkg::IN_TDATA_W-1:0]   s_tdata,  // seq_id[15:0], done_ok[16], zero pad
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// resp_code[0], dispatch_valid[1], dispatch_id[17:2], queue_count[27:18],
	// queue_mode[29:28], busy_flag[30], cleared_count[40:31], done_total[72:41],
	// fail_total[104:73], went_empty[105], zero pad
	output logic [sdq_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sdq_pkg::DEPTH_W-1:0]      cfg_data
);
	import sdq_pkg::*;

	sdq_cmd_t    cmd;
	sdq_status_t status;

	assign cfg_ready = 1'b1;

	sdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sdq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tdata  (m_tdata)
	);

endmodule

[src/sdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/sdq_ctrl.sv]
// Controller state machine: sequences accept, execute, head read and result hold.
// Depends on sdq_pkg.
module sdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  sdq_pkg::sdq_status_t status,
	output sdq_pkg::sdq_cmd_t   cmd
);
	import sdq_pkg::*;

	state_t state_q, state_d;
	logic   dispatch_go;
	logic   go_stop;

	// Dispatch decision for the request held in the datapath.
	always_comb begin
		dispatch_go = 1'b0;
		go_stop     = 1'b0;
		case (status.req)
			REQ_ENQUEUE: begin
				dispatch_go = !status.full && !status.busy &&
					(status.mode == MODE_STOPPED || status.mode == MODE_RUNNING);
			end
			REQ_COMPLETE: begin
				if (status.mode == MODE_RUNNING) begin
					dispatch_go = !status.count_zero;
					go_stop     = status.count_zero;
				end
			end
			REQ_RESUME: begin
				if (status.mode == MODE_PAUSED && !status.busy) begin
					dispatch_go = !status.count_zero;
					go_stop     = status.count_zero;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_EXEC;
			ST_EXEC: state_d = dispatch_go ? ST_READ : ST_OUT;
			ST_READ: state_d = ST_CAP;
			ST_CAP:  state_d = ST_OUT;
			ST_OUT:  if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_EXEC: begin
				cmd.set_empty = go_stop;
				case (status.req)
					REQ_ENQUEUE: begin
						cmd.reject = status.full;
						cmd.enq    = !status.full;
						if (!status.full && status.mode == MODE_STOPPED) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_val = MODE_RUNNING;
						end
					end
					REQ_COMPLETE: begin
						cmd.complete = 1'b1;
						if (go_stop) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_val = MODE_STOPPED;
						end
					end
					REQ_CLEAR: cmd.clear = 1'b1;
					REQ_PAUSE: begin
						cmd.mode_we  = 1'b1;
						cmd.mode_val = MODE_PAUSED;
					end
					REQ_RESUME: begin
						if (status.mode == MODE_PAUSED) begin
							cmd.mode_we  = 1'b1;
							cmd.mode_val = go_stop ? MODE_STOPPED : MODE_RUNNING;
						end
					end
					default: begin
					end
				endcase
			end
			ST_READ: begin
			end
			ST_CAP:  cmd.pop = 1'b1;
			ST_OUT:  m_tvalid = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

[src/sdq_datapath.sv]
// Datapath: request latch, queue pointers, handle RAM, mode/busy, counters, result.
// Depends on sdq_pkg and sdq_ram.
module sdq_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sdq_pkg::DEPTH_W-1:0]    cfg_data,
	input  logic [sdq_pkg::REQ_W-1:0]      s_tuser,
	input  logic [sdq_pkg::IN_TDATA_W-1:0] s_tdata,
	input  sdq_pkg::sdq_cmd_t              cmd,
	output sdq_pkg::sdq_status_t           status,
	output logic [sdq_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import sdq_pkg::*;

	req_t                   req_q;
	logic [HANDLE_BITS-1:0] sid_q;
	logic                   ok_q;
	logic [PTR_W-1:0]       head_q, tail_q;
	logic [CNT_W-1:0]       count_q;
	mode_t                  mode_q;
	logic                   busy_q;
	logic [TOTAL_W-1:0]     succ_q, fail_q;
	logic [DEPTH_W-1:0]     max_depth_q;
	logic                   resp_q, dv_q, empty_q;
	logic [ID_W-1:0]        did_q;
	logic [CNT_W-1:0]       cleared_q;
	logic [HANDLE_BITS-1:0] rd_data;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (32'(p) == QUEUE_CAPACITY - 1) ? '0 : p + PTR_W'(1);
	endfunction

	sdq_ram #(
		.WIDTH(HANDLE_BITS),
		.DEPTH(QUEUE_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.enq),
		.waddr (tail_q),
		.wdata (sid_q),
		.raddr (head_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			mode_q      <= MODE_STOPPED;
			busy_q      <= 1'b0;
			succ_q      <= '0;
			fail_q      <= '0;
			max_depth_q <= MAX_DEPTH_RESET;
		end else begin
			if (cfg_we) max_depth_q <= cfg_data;
			if (cmd.mode_we) mode_q <= cmd.mode_val;
			if (cmd.enq) begin
				tail_q  <= next_ptr(tail_q);
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.complete) begin
				busy_q <= 1'b0;
				if (ok_q) succ_q <= succ_q + TOTAL_W'(1);
				else      fail_q <= fail_q + TOTAL_W'(1);
			end
			if (cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			if (cmd.pop) begin
				head_q  <= next_ptr(head_q);
				count_q <= count_q - CNT_W'(1);
				busy_q  <= 1'b1;
			end
		end
	end

	// request latch and per-item result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_t'(s_tuser);
			sid_q     <= HANDLE_BITS'(s_tdata[ID_W-1:0]);
			ok_q      <= s_tdata[ID_W];
			resp_q    <= 1'b0;
			dv_q      <= 1'b0;
			did_q     <= '0;
			cleared_q <= '0;
			empty_q   <= 1'b0;
		end
		if (cmd.reject) resp_q <= 1'b1;
		if (cmd.set_empty) empty_q <= 1'b1;
		if (cmd.clear) cleared_q <= count_q;
		if (cmd.pop) begin
			dv_q  <= 1'b1;
			did_q <= ID_W'(rd_data);
		end
	end

	assign status.req        = req_q;
	assign status.mode       = mode_q;
	assign status.busy       = busy_q;
	assign status.count_zero = (count_q == '0);
	assign status.full       = (32'(count_q) >= 32'(max_depth_q)) ||
		(32'(count_q) >= QUEUE_CAPACITY);

	assign m_tdata = {6'b0, empty_q, fail_q, succ_q, DEPTH_W'(cleared_q), busy_q,
		mode_q, DEPTH_W'(count_q), did_q, dv_q, resp_q};

endmodule

[src/sdq_checker.sv]
// Port-level checks of sequence_dispatch_queue_unit, bound to the top level.
// Depends on sdq_pkg.
module sdq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sdq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import sdq_pkg::*;

	// one item in flight: never ready for input while a result is shown
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// a dispatch always leaves the block busy and running
	a_disp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> (m_tdata[30] && m_tdata[29:28] == MODE_RUNNING))
		else $error("dispatch without busy/running");

	// empty dispatch stops the queue and dispatches nothing
	a_went_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[105]) |->
			(!m_tdata[1] && m_tdata[29:28] == MODE_STOPPED && m_tdata[27:18] == '0))
		else $error("went_empty inconsistent");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[27:18]) <= QUEUE_CAPACITY))
		else $error("queue_count above capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind sequence_dispatch_queue_unit sdq_checker u_sdq_checker (.*);

[sim/sdq_dispatch_checker.sv]
// Checker for the sequence dispatch queue: watches the request, result and
// max_depth channels, predicts each result and compares it field by field.
// Depends on sdq_pkg only.
module sdq_dispatch_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [sdq_pkg::REQ_W-1:0]       s_tuser,  // req_type
	input  logic [sdq_pkg::IN_TDATA_W-1:0]  s_tdata,  // seq_id[15:0], done_ok[16], zero pad
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// resp_code, dispatch_valid, dispatch_id, queue_count, queue_mode, busy_flag,
	// cleared_count, done_total, fail_total, went_empty, zero pad
	input  logic [sdq_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sdq_pkg::DEPTH_W-1:0]     cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import sdq_pkg::*;

	// declared from the top bit down, so it lines up with m_tdata
	typedef struct packed {
		logic               went_empty;
		logic [TOTAL_W-1:0] fail_total;
		logic [TOTAL_W-1:0] done_total;
		logic [DEPTH_W-1:0] cleared_count;
		logic               busy_flag;
		mode_t              queue_mode;
		logic [DEPTH_W-1:0] queue_count;
		logic [ID_W-1:0]    dispatch_id;
		logic               dispatch_valid;
		logic               resp_code;
	} dispatch_result_t;

	localparam int RESULT_W = $bits(dispatch_result_t);

	logic [ID_W-1:0]    handle_copy [QUEUE_CAPACITY];
	logic [PTR_W-1:0]   pop_ptr;
	logic [PTR_W-1:0]   push_ptr;
	logic [CNT_W-1:0]   queued;
	mode_t              run_mode;
	logic               job_active;
	logic [TOTAL_W-1:0] ok_runs;
	logic [TOTAL_W-1:0] bad_runs;
	logic [DEPTH_W-1:0] depth_limit;
	dispatch_result_t   expected_results [$];

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic string describe(input dispatch_result_t r);
		return $sformatf(
			"rej=%0d disp=%0d id=%h cnt=%0d mode=%0d busy=%0d clr=%0d ok=%0d fail=%0d empty=%0d",
			r.resp_code, r.dispatch_valid, r.dispatch_id, r.queue_count, r.queue_mode,
			r.busy_flag, r.cleared_count, r.done_total, r.fail_total, r.went_empty);
	endfunction

	// an attempt on an empty queue stops the dispatcher even when paused
	task automatic dispatch_head(inout dispatch_result_t r);
		if (queued == 0) begin
			run_mode = MODE_STOPPED;
			r.went_empty = 1'b1;
		end else if (run_mode != MODE_PAUSED) begin
			r.dispatch_id = handle_copy[pop_ptr];
			r.dispatch_valid = 1'b1;
			pop_ptr = ring_next(pop_ptr);
			queued = queued - 1'b1;
			job_active = 1'b1;
		end
	endtask

	task automatic predict_request(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
			input logic ok, output dispatch_result_t r);
		r = '0;
		case (req)
		REQ_ENQUEUE: begin
			if (queued >= depth_limit || queued >= QUEUE_CAPACITY) begin
				r.resp_code = 1'b1;
			end else begin
				handle_copy[push_ptr] = id;
				push_ptr = ring_next(push_ptr);
				queued = queued + 1'b1;
				if (run_mode == MODE_STOPPED)
					run_mode = MODE_RUNNING;
				if (!job_active && run_mode == MODE_RUNNING)
					dispatch_head(r);
			end
		end
		REQ_COMPLETE: begin
			job_active = 1'b0;
			if (ok)
				ok_runs = ok_runs + 1'b1;
			else
				bad_runs = bad_runs + 1'b1;
			if (run_mode == MODE_RUNNING)
				dispatch_head(r);
		end
		REQ_CLEAR: begin
			r.cleared_count = queued;
			queued = '0;
			pop_ptr = '0;
			push_ptr = '0;
		end
		REQ_PAUSE: begin
			run_mode = MODE_PAUSED;
		end
		REQ_RESUME: begin
			if (run_mode == MODE_PAUSED) begin
				run_mode = MODE_RUNNING;
				if (!job_active)
					dispatch_head(r);
			end
		end
		default: ;  // status and the spare codes change nothing
		endcase
		r.queue_count = queued;
		r.queue_mode = run_mode;
		r.busy_flag = job_active;
		r.done_total = ok_runs;
		r.fail_total = bad_runs;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dispatch_result_t predicted;
		dispatch_result_t observed;
		if (!arst_n) begin
			pop_ptr = '0;
			push_ptr = '0;
			queued = '0;
			run_mode = MODE_STOPPED;
			job_active = 1'b0;
			ok_runs = '0;
			bad_runs = '0;
			depth_limit = MAX_DEPTH_RESET;
			expected_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W], predicted);
				expected_results.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				observed = dispatch_result_t'(m_tdata[RESULT_W-1:0]);
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item with nothing expected: %s", $realtime,
							describe(observed));
				end else begin
					predicted = expected_results.pop_front();
					if (observed !== predicted) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result item differs", $realtime);
							$display("  expected %s", describe(predicted));
							$display("  actual   %s", describe(observed));
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				depth_limit = cfg_data;
			outstanding = expected_results.size();
		end
	end

endmodule

[sim/sequence_dispatch_queue_unit_test.sv]
// Testbench top for sequence_dispatch_queue_unit: drives requests, max_depth
// writes and result backpressure, and gives the verdict.
// Depends on sdq_pkg, the block's RTL and sdq_dispatch_checker.
module sequence_dispatch_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sdq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
	localparam int MAX_GAP       = 18;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 160;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [REQ_W-1:0]       s_tuser;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [DEPTH_W-1:0]     cfg_data;
	int                     mismatches;
	int                     outstanding;
	bit                     tx_burst;
	bit                     rx_burst;

	always #5 clk = ~clk;

	sequence_dispatch_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sdq_dispatch_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
			input logic ok);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= IN_TDATA_W'({ok, id});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_depth(input logic [DEPTH_W-1:0] depth);
		cfg_valid <= 1'b1;
		cfg_data <= depth;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_item();
		int pick;
		logic [REQ_W-1:0] req;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			req = REQ_ENQUEUE;
		else if (pick < 75)
			req = REQ_COMPLETE;
		else if (pick < 78)
			req = REQ_CLEAR;
		else if (pick < 82)
			req = REQ_STATUS;
		else if (pick < 89)
			req = REQ_PAUSE;
		else if (pick < 97)
			req = REQ_RESUME;
		else
			req = pick[0] ? REQ_SPARE_A : REQ_SPARE_B;
		send_item(req, ID_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
	endtask

	// result side: random stall before each item, with stall-free stretches
	initial begin
		int stall;
		int taken;
		m_tready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin
		logic [DEPTH_W-1:0] depth_plan [RANDOM_PHASES];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		tx_burst = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed walk through the modes, default max_depth
		send_item(REQ_STATUS, 16'h0000, 1'b0);
		send_item(REQ_COMPLETE, 16'h0000, 1'b1);  // completion with nothing running
		send_item(REQ_RESUME, 16'h0000, 1'b0);    // resume from stopped does nothing
		send_item(REQ_ENQUEUE, 16'h0000, 1'b0);
		send_item(REQ_ENQUEUE, 16'hFFFF, 1'b1);
		send_item(REQ_ENQUEUE, 16'hA5A5, 1'b0);
		send_item(REQ_PAUSE, 16'h0000, 1'b0);
		send_item(REQ_ENQUEUE, 16'h5A5A, 1'b1);   // accepted while paused
		send_item(REQ_COMPLETE, 16'hFFFF, 1'b0);  // failure, no dispatch while paused
		send_item(REQ_SPARE_A, 16'hFFFF, 1'b1);
		send_item(REQ_SPARE_B, 16'h0000, 1'b0);
		send_item(REQ_RESUME, 16'h0000, 1'b0);
		send_item(REQ_COMPLETE, 16'h0000, 1'b1);
		send_item(REQ_CLEAR, 16'h0000, 1'b0);
		send_item(REQ_COMPLETE, 16'h0000, 1'b1);  // queue empty, falls to stopped
		send_item(REQ_PAUSE, 16'h0000, 1'b0);
		send_item(REQ_RESUME, 16'h0000, 1'b0);    // empty queue on resume
		drain_results();
		write_depth('0);
		send_item(REQ_ENQUEUE, 16'h1234, 1'b0);   // rejected at zero depth
		drain_results();
		write_depth(10'd1);
		send_item(REQ_PAUSE, 16'h0000, 1'b0);
		send_item(REQ_ENQUEUE, 16'h1234, 1'b1);
		send_item(REQ_ENQUEUE, 16'h4321, 1'b0);
		send_item(REQ_CLEAR, 16'h0000, 1'b0);

		// max_depth above the storage: the storage limit decides
		drain_results();
		write_depth(10'd1023);
		send_item(REQ_PAUSE, 16'h0000, 1'b0);
		repeat (QUEUE_CAPACITY + 1)
			send_item(REQ_ENQUEUE, ID_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
		send_item(REQ_RESUME, 16'h0000, 1'b0);
		repeat (3)
			send_item(REQ_COMPLETE, 16'h0000, 1'($urandom_range(0, 1)));
		send_item(REQ_CLEAR, 16'h0000, 1'b0);

		depth_plan = '{10'd4, 10'd1, 10'd512, 10'd0, 10'd37, 10'd0, 10'd1023, 10'd500};
		depth_plan[5] = DEPTH_W'($urandom_range(0, 1023));
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			write_depth(depth_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 149) == 0)
					drain_results();
				send_random_item();
			end
		end
		drain_results();

		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
